// ===== hw/rtl/dhes_pkg.sv =====
// Shared types, constants and helpers of the Date header converter.
package dhes_pkg;

  localparam int ZONE_COUNT = 19;

  typedef struct packed {
    logic step;
    logic eos;
    logic clear;
  } parse_cmd_t;

  typedef enum logic [2:0] {
    CS_NONE,
    CS_LOAD,
    CS_DAYS,
    CS_HOURS,
    CS_MINS,
    CS_SECS
  } conv_step_t;

  typedef struct packed {
    conv_step_t step;
    logic       load_out;
  } conv_cmd_t;

  typedef struct packed {
    logic        rejected;
    logic [7:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [13:0] zone;
    logic        zone_neg;
  } parse_res_t;

  localparam logic [31:0] ZONE_TEXT [ZONE_COUNT] = '{
    {"EST", 8'h00}, {"CST", 8'h00}, {"MST", 8'h00}, {"PST", 8'h00},
    {"EDT", 8'h00}, {"CDT", 8'h00}, {"MDT", 8'h00}, {"PDT", 8'h00},
    {"CET", 8'h00}, {"MET", 8'h00}, {"MEZ", 8'h00}, {"MSK", 8'h00},
    {"HKT", 8'h00}, {"JST", 8'h00}, {"KST", 8'h00}, "CAST",
    "EAST", "NZST", {"EET", 8'h00}
  };
  localparam logic [3:0] ZONE_LEN [ZONE_COUNT] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3
  };
  localparam logic [13:0] ZONE_MAG [ZONE_COUNT] = '{
    14'd500, 14'd600, 14'd700, 14'd800, 14'd400, 14'd500, 14'd600, 14'd700,
    14'd100, 14'd100, 14'd100, 14'd300, 14'd800, 14'd900, 14'd900, 14'd930,
    14'd1000, 14'd1200, 14'd200
  };
  localparam logic ZONE_NEG [ZONE_COUNT] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d,
                                            input logic [15:0] mx);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, d};
    return (v > {4'b0, mx}) ? mx : v[15:0];
  endfunction

endpackage

// ===== hw/rtl/dhes_if.sv =====
// Valid/ready channel interfaces for header characters and results.
interface dhes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source(output valid, char_code, is_last, input ready);
  modport sink(input valid, char_code, is_last, output ready);
endinterface

interface dhes_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] epoch_seconds;
  logic        ok;
  modport source(output valid, epoch_seconds, ok, input ready);
  modport sink(input valid, epoch_seconds, ok, output ready);
endinterface

// ===== hw/rtl/dhes_parser.sv =====
// Character parser: grammar phases, field accumulators and zone name lookup.
module dhes_parser #(
  parameter int TZ_NAME_CHARS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dhes_pkg::parse_cmd_t cmd,
  input  logic [7:0]           char_code,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  output dhes_pkg::parse_res_t res
);

  localparam int IDX_W = (TZ_NAME_CHARS > 1) ? $clog2(TZ_NAME_CHARS) : 1;

  typedef enum logic [4:0] {
    P_LEAD, P_WDAY, P_WSDAY, P_DAY, P_WSMON, P_MJ, P_MJU, P_MM, P_MMA, P_MA,
    P_MSKIP, P_WSYEAR, P_YEAR, P_WSHOUR, P_HOUR, P_MIN, P_SEC, P_WSZONE,
    P_ZONE, P_WSNAME, P_NAME, P_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  pivot_r;
  logic [7:0]  day_r, day_nxt, hour_r, hour_nxt, min_r, min_nxt, sec_r, sec_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [15:0] year_r, year_nxt;
  logic [13:0] zone_r, zone_nxt;
  logic        zneg_r, zneg_nxt, rej_r, rej_nxt;
  logic [3:0]  len_r;
  logic [7:0]  name_r [TZ_NAME_CHARS];
  logic [7:0]  nm [4];
  logic        name_we, resolve, go, hit, keep;
  logic [13:0] hit_mag;
  logic        hit_neg;
  logic [15:0] tmp;
  logic [7:0]  c;
  logic        c_ws, c_dig, c_alpha, c_zero;

  assign c       = cmd.eos ? 8'h00 : char_code;
  assign c_ws    = (c == 8'h20) || (c == 8'h09);
  assign c_dig   = (c >= "0") && (c <= "9");
  assign c_alpha = ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  assign c_zero  = (c == 8'h00);

  function automatic logic ci(input logic [7:0] ch, input logic [7:0] up);
    return (ch | 8'h20) == (up | 8'h20);
  endfunction

  genvar g;
  for (g = 0; g < 4; g++) begin : g_nm
    if (g < TZ_NAME_CHARS) begin : g_held
      assign nm[g] = (len_r > 4'(g)) ? name_r[g] : 8'h00;
    end else begin : g_none
      assign nm[g] = 8'h00;
    end
  end

  assign keep = (nm[0] == "G" && nm[1] == "M" && nm[2] == "T") ||
                (nm[0] == "U" && nm[1] == "T");

  always_comb begin
    hit     = 1'b0;
    hit_mag = '0;
    hit_neg = 1'b0;
    for (int k = 0; k < dhes_pkg::ZONE_COUNT; k++) begin
      if (!hit && len_r == dhes_pkg::ZONE_LEN[k] &&
          {nm[0], nm[1], nm[2], nm[3]} == dhes_pkg::ZONE_TEXT[k]) begin
        hit     = 1'b1;
        hit_mag = dhes_pkg::ZONE_MAG[k];
        hit_neg = dhes_pkg::ZONE_NEG[k];
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    zone_nxt  = zone_r;
    zneg_nxt  = zneg_r;
    rej_nxt   = rej_r;
    name_we   = 1'b0;
    resolve   = 1'b0;
    tmp       = '0;
    go        = cmd.step && (phase_r != P_DONE);
    for (int it = 0; it < 6; it++) begin
      if (go) begin
        go = 1'b0;
        case (phase_nxt)
          P_LEAD: begin
            if (c_zero) begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end else if (!c_ws) begin
              phase_nxt = P_WDAY; go = 1'b1;
            end
          end
          P_WDAY: begin
            if (!c_alpha) begin
              phase_nxt = P_WSDAY;
              go = (c != ",");
            end
          end
          P_WSDAY: begin
            if (!c_ws) begin
              phase_nxt = P_DAY; go = 1'b1;
            end
          end
          P_DAY: begin
            if (c_dig) begin
              tmp = dhes_pkg::add_digit({8'b0, day_nxt}, c[3:0], 16'd255);
              day_nxt = tmp[7:0];
            end else if (day_nxt == 8'd0 || day_nxt > 8'd31) begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end else begin
              phase_nxt = P_WSMON; go = 1'b1;
            end
          end
          P_WSMON: begin
            if (!c_ws) begin
              phase_nxt = P_MSKIP;
              if (c == "J")          phase_nxt = P_MJ;
              else if (ci(c, "F"))   mon_nxt = 4'd2;
              else if (ci(c, "M"))   phase_nxt = P_MM;
              else if (ci(c, "A"))   phase_nxt = P_MA;
              else if (ci(c, "S"))   mon_nxt = 4'd9;
              else if (ci(c, "O"))   mon_nxt = 4'd10;
              else if (ci(c, "N"))   mon_nxt = 4'd11;
              else if (ci(c, "D"))   mon_nxt = 4'd12;
              else begin
                rej_nxt = 1'b1; phase_nxt = P_DONE;
              end
            end
          end
          P_MJ: begin
            if (ci(c, "U")) phase_nxt = P_MJU;
            else if (ci(c, "A")) begin
              mon_nxt = 4'd1; phase_nxt = P_MSKIP;
            end else begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end
          end
          P_MJU: begin
            phase_nxt = P_MSKIP;
            if (ci(c, "N"))      mon_nxt = 4'd6;
            else if (ci(c, "L")) mon_nxt = 4'd7;
            else begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end
          end
          P_MM: begin
            if (ci(c, "A")) phase_nxt = P_MMA;
            else begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end
          end
          P_MMA: begin
            phase_nxt = P_MSKIP;
            if (ci(c, "Y"))      mon_nxt = 4'd5;
            else if (ci(c, "R")) mon_nxt = 4'd3;
            else begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end
          end
          P_MA: begin
            phase_nxt = P_MSKIP;
            if (ci(c, "P"))      mon_nxt = 4'd4;
            else if (ci(c, "U")) mon_nxt = 4'd8;
            else begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end
          end
          P_MSKIP: begin
            if (!c_alpha) begin
              phase_nxt = P_WSYEAR; go = 1'b1;
            end
          end
          P_WSYEAR: begin
            if (!c_ws) begin
              phase_nxt = P_YEAR; go = 1'b1;
            end
          end
          P_YEAR: begin
            if (c_dig) begin
              year_nxt = dhes_pkg::add_digit(year_nxt, c[3:0], 16'd65535);
            end else begin
              if (year_nxt < 16'd100) begin
                year_nxt = year_nxt +
                           ((year_nxt > {9'b0, pivot_r}) ? 16'd1900 : 16'd2000);
              end
              phase_nxt = P_WSHOUR; go = 1'b1;
            end
          end
          P_WSHOUR: begin
            if (!c_ws) begin
              phase_nxt = P_HOUR; go = 1'b1;
            end
          end
          P_HOUR: begin
            if (c_dig) begin
              tmp = dhes_pkg::add_digit({8'b0, hour_nxt}, c[3:0], 16'd255);
              hour_nxt = tmp[7:0];
            end else if (c != ":" || hour_nxt >= 8'd24) begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end else begin
              phase_nxt = P_MIN;
            end
          end
          P_MIN: begin
            if (c_dig) begin
              tmp = dhes_pkg::add_digit({8'b0, min_nxt}, c[3:0], 16'd255);
              min_nxt = tmp[7:0];
            end else if (min_nxt >= 8'd60) begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end else if (c == ":") begin
              phase_nxt = P_SEC;
            end else begin
              phase_nxt = P_WSZONE; go = 1'b1;
            end
          end
          P_SEC: begin
            if (c_dig) begin
              tmp = dhes_pkg::add_digit({8'b0, sec_nxt}, c[3:0], 16'd255);
              sec_nxt = tmp[7:0];
            end else if (sec_nxt >= 8'd60) begin
              rej_nxt = 1'b1; phase_nxt = P_DONE;
            end else begin
              phase_nxt = P_WSZONE; go = 1'b1;
            end
          end
          P_WSZONE: begin
            if (!c_ws) begin
              phase_nxt = P_ZONE;
              if (c == "-") zneg_nxt = 1'b1;
              else if (c != "+") go = 1'b1;
            end
          end
          P_ZONE: begin
            if (c_dig) begin
              tmp = dhes_pkg::add_digit({2'b0, zone_nxt}, c[3:0], 16'd16383);
              zone_nxt = tmp[13:0];
            end else begin
              phase_nxt = P_WSNAME; go = 1'b1;
            end
          end
          P_WSNAME: begin
            if (c_alpha) begin
              phase_nxt = P_NAME; go = 1'b1;
            end else if (!c_ws) begin
              phase_nxt = P_DONE;
            end
          end
          P_NAME: begin
            if (c_zero) begin
              resolve = 1'b1; phase_nxt = P_DONE;
            end else begin
              name_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    if (resolve && !keep) begin
      zone_nxt = hit ? hit_mag : 14'd0;
      zneg_nxt = hit && hit_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= 7'd50;
    end else if (cfg_we) begin
      pivot_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      phase_r <= P_LEAD;
      day_r   <= '0;
      mon_r   <= '0;
      year_r  <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      zone_r  <= '0;
      zneg_r  <= 1'b0;
      rej_r   <= 1'b0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      day_r   <= day_nxt;
      mon_r   <= mon_nxt;
      year_r  <= year_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      zone_r  <= zone_nxt;
      zneg_r  <= zneg_nxt;
      rej_r   <= rej_nxt;
      if (name_we && len_r < 4'd15) begin
        len_r <= len_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (name_we && len_r < 4'(TZ_NAME_CHARS)) begin
      name_r[len_r[IDX_W-1:0]] <= c;
    end
  end

  assign res.rejected = rej_r;
  assign res.day      = day_r;
  assign res.month    = mon_r;
  assign res.year     = year_r;
  assign res.hour     = hour_r;
  assign res.minute   = min_r;
  assign res.second   = sec_r;
  assign res.zone     = zone_r;
  assign res.zone_neg = zneg_r;

endmodule

// ===== hw/rtl/dhes_conv.sv =====
// Epoch arithmetic: stepwise day count, zone split and seconds, result register.
module dhes_conv (
  input  logic                 clk,
  input  dhes_pkg::conv_cmd_t  cmd,
  input  dhes_pkg::parse_res_t res,
  output logic [47:0]          epoch_seconds,
  output logic                 ok
);

  logic [47:0]        days_r, acc_r, epoch_r;
  logic               ok_r;
  logic signed [16:0] yr_r, yr_nxt, yq;
  logic [7:0]         q_r;
  logic [6:0]         r_r;
  logic [3:0]         mon;
  logic [2:0]         corr;
  logic               leap, adj;
  logic [9:0]         days0;
  logic [26:0]        prod;
  logic signed [25:0] yrm;
  logic [47:0]        hh, mm;

  always_comb begin
    mon = res.month - 4'd1;
    case (mon)
      4'd2, 4'd3:        corr = 3'd3;
      4'd4, 4'd5:        corr = 3'd4;
      4'd6, 4'd7, 4'd8:  corr = 3'd5;
      4'd9, 4'd10:       corr = 3'd6;
      4'd11:             corr = 3'd7;
      default:           corr = 3'd0;
    endcase
    leap   = (mon > 4'd1) && (res.year[1:0] == 2'b00);
    days0  = ({6'b0, mon} << 5) - {6'b0, mon} + {2'b0, res.day} - 10'd1 -
             {7'b0, corr} + {9'b0, leap};
    prod   = {13'b0, res.zone} * 27'd5243;
    yr_nxt = $signed({1'b0, res.year}) - 17'sd1970;
    yrm    = 26'(yr_r) * 26'sd365;
    yq     = yr_r[16] ? ((yr_r + 17'sd3) >>> 2) : (yr_r >>> 2);
    adj    = !yr_r[16] && (yr_r[1:0] == 2'b11);
    hh     = res.zone_neg ? 48'(res.hour) + 48'(q_r) : 48'(res.hour) - 48'(q_r);
    mm     = res.zone_neg ? 48'(res.minute) + 48'(r_r) : 48'(res.minute) - 48'(r_r);
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      dhes_pkg::CS_LOAD: begin
        days_r <= 48'(days0);
        yr_r   <= yr_nxt;
        q_r    <= prod[26:19];
      end
      dhes_pkg::CS_DAYS: begin
        days_r <= days_r + 48'(yrm) + 48'(yq) + {47'b0, adj};
        r_r    <= 7'(res.zone - 14'(q_r) * 14'd100);
      end
      dhes_pkg::CS_HOURS: acc_r <= hh + (days_r << 4) + (days_r << 3);
      dhes_pkg::CS_MINS:  acc_r <= mm + (acc_r << 6) - (acc_r << 2);
      dhes_pkg::CS_SECS:  acc_r <= 48'(res.second) + (acc_r << 6) - (acc_r << 2);
      default: ;
    endcase
    if (cmd.load_out) begin
      epoch_r <= res.rejected ? 48'd0 : acc_r;
      ok_r    <= !res.rejected;
    end
  end

  assign epoch_seconds = epoch_r;
  assign ok            = ok_r;

endmodule

// ===== hw/rtl/dhes_ctrl.sv =====
// Sequencer: character handshake, end-of-string step, arithmetic steps, result valid.
module dhes_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic                 out_ready,
  output logic                 in_ready,
  output logic                 out_valid,
  output dhes_pkg::parse_cmd_t pcmd,
  output dhes_pkg::conv_cmd_t  ccmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EOS, S_LOAD, S_DAYS, S_HOURS, S_MINS, S_SECS, S_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pcmd          = '0;
    ccmd.step     = dhes_pkg::CS_NONE;
    ccmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        pcmd.step = in_valid;
        if (in_valid && in_last) state_nxt = S_EOS;
      end
      S_EOS: begin
        pcmd.step = 1'b1;
        pcmd.eos  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ccmd.step = dhes_pkg::CS_LOAD;
        state_nxt = S_DAYS;
      end
      S_DAYS: begin
        ccmd.step = dhes_pkg::CS_DAYS;
        state_nxt = S_HOURS;
      end
      S_HOURS: begin
        ccmd.step = dhes_pkg::CS_HOURS;
        state_nxt = S_MINS;
      end
      S_MINS: begin
        ccmd.step = dhes_pkg::CS_MINS;
        state_nxt = S_SECS;
      end
      S_SECS: begin
        ccmd.step = dhes_pkg::CS_SECS;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (out_free) begin
          ccmd.load_out = 1'b1;
          pcmd.clear    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/date_header_to_epoch_seconds.sv =====
// Date header to epoch seconds converter: top level.
// Takes a mail or news Date header one character per transaction and gives one
// result transaction (seconds since 1970 and an ok flag) for the transaction that
// carries the last character. A character that is not last leaves the block idle
// and ready for the next one. After the last character the next transaction is taken
// only when these steps are done: parsing it, the end-of-string step with zone name
// lookup, five steps of the epoch arithmetic unit, and loading the result register;
// that load waits while an earlier result in the register has not been taken.
module date_header_to_epoch_seconds #(
  parameter int TZ_NAME_CHARS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  dhes_in_if.sink      in_chan,
  dhes_out_if.source   out_chan,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  dhes_pkg::parse_cmd_t pcmd;
  dhes_pkg::conv_cmd_t  ccmd;
  dhes_pkg::parse_res_t res;

  dhes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.is_last),
    .out_ready (out_chan.ready),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .pcmd      (pcmd),
    .ccmd      (ccmd)
  );

  dhes_parser #(
    .TZ_NAME_CHARS (TZ_NAME_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pcmd),
    .char_code (in_chan.char_code),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  dhes_conv u_conv (
    .clk           (clk),
    .cmd           (ccmd),
    .res           (res),
    .epoch_seconds (out_chan.epoch_seconds),
    .ok            (out_chan.ok)
  );

endmodule
